[hw/rtl/dtde_pkg.sv]
// ----------------------------------------------------------------------------
// dtde_pkg - shared types, constants and digit helpers
// Command codes, BCD limits and the per-digit step rules of the date and
// time digit editor.
// ----------------------------------------------------------------------------
package dtde_pkg;

    // Command carried in the input tuser
    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_SET  = 2'd1,
        CMD_UP   = 2'd2,
        CMD_DOWN = 2'd3
    } cmd_t;

    typedef logic [7:0] bcd_t;
    typedef logic [3:0] pos_t;

    localparam pos_t POS_IDLE  = 4'd0;
    localparam pos_t POS_FIRST = 4'd1;
    localparam pos_t POS_LAST  = 4'd10;

    // Editing positions
    localparam pos_t POS_HOUR_T   = 4'd1;
    localparam pos_t POS_HOUR_O   = 4'd2;
    localparam pos_t POS_MINUTE_T = 4'd3;
    localparam pos_t POS_MINUTE_O = 4'd4;
    localparam pos_t POS_MONTH_T  = 4'd5;
    localparam pos_t POS_MONTH_O  = 4'd6;
    localparam pos_t POS_DAY_T    = 4'd7;
    localparam pos_t POS_DAY_O    = 4'd8;
    localparam pos_t POS_YEAR_T   = 4'd9;
    localparam pos_t POS_YEAR_O   = 4'd10;

    // BCD limits and replacement values
    localparam bcd_t BCD_00 = 8'h00;
    localparam bcd_t BCD_01 = 8'h01;
    localparam bcd_t BCD_02 = 8'h02;
    localparam bcd_t BCD_09 = 8'h09;
    localparam bcd_t BCD_10 = 8'h10;
    localparam bcd_t BCD_12 = 8'h12;
    localparam bcd_t BCD_20 = 8'h20;
    localparam bcd_t BCD_23 = 8'h23;
    localparam bcd_t BCD_28 = 8'h28;
    localparam bcd_t BCD_29 = 8'h29;
    localparam bcd_t BCD_30 = 8'h30;
    localparam bcd_t BCD_31 = 8'h31;
    localparam bcd_t BCD_50 = 8'h50;

    localparam int TDATA_IN_W  = 32;
    localparam int TDATA_OUT_W = 48;

    function automatic logic long_month(input bcd_t m);
        return m inside {8'h01, 8'h03, 8'h05, 8'h07, 8'h08, 8'h10, 8'h12};
    endfunction

    function automatic logic short_month(input bcd_t m);
        return m inside {8'h04, 8'h06, 8'h09, 8'h11};
    endfunction

    // Raise the tens digit below the limit, else keep only the ones
    function automatic bcd_t tens_up(input bcd_t v, input logic [3:0] limit);
        if (v[7:4] < limit)
            return bcd_t'(v + BCD_10);
        return {4'h0, v[3:0]};
    endfunction

    // Raise the ones digit below nine, else keep only the tens
    function automatic bcd_t ones_up(input bcd_t v);
        if (v[3:0] < 4'h9)
            return bcd_t'(v + BCD_01);
        return {v[7:4], 4'h0};
    endfunction

    // Lower the tens digit, wrapping by the given amount at zero
    function automatic bcd_t tens_down(input bcd_t v, input bcd_t wrap_add);
        if (v[7:4] == 4'h0)
            return bcd_t'(v + wrap_add);
        return bcd_t'(v - BCD_10);
    endfunction

    // Lower the ones digit, wrapping to nine at zero
    function automatic bcd_t ones_down(input bcd_t v);
        if (v[3:0] == 4'h0)
            return bcd_t'(v + BCD_09);
        return bcd_t'(v - BCD_01);
    endfunction

    // Limit the day to the month length; leap test uses the low year bits
    function automatic bcd_t clamp_day(input bcd_t day, input bcd_t month,
                                       input bcd_t year, input bcd_t c31,
                                       input bcd_t c29, input bcd_t c28);
        bcd_t d;
        logic leap;
        d    = day;
        leap = (year[1:0] == 2'b00);
        if (d > BCD_31 && long_month(month))
            d = c31;
        if (d > BCD_30 && short_month(month))
            d = BCD_30;
        if (d > BCD_29 && month == BCD_02 && leap)
            d = c29;
        if (d > BCD_28 && month == BCD_02 && !leap)
            d = c28;
        return d;
    endfunction

endpackage

[hw/rtl/date_time_digit_editor.sv]
// ----------------------------------------------------------------------------
// date_time_digit_editor - digit-by-digit editor for a BCD date and time
// Loads hour, minute, month, day and year, steps one digit at a time with
// up, down and set keys, and flags done after the last position.
// ----------------------------------------------------------------------------
// One word in gives one word out. A word is taken every cycle in which the
// result register is empty or is being emptied, so the block sustains one
// word per clock; the result is registered and appears in the cycle after
// acceptance. The rate is set by the loop through the state bytes: each
// word's compare and add on one byte is worked out from the state registers
// and written back at the same edge as the result register.
module date_time_digit_editor
    import dtde_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // tdata from bit 0: new_hour[5:0], new_minute[6:0], new_month[4:0],
    //                   new_day[5:0], new_year[7:0]
    input  logic [TDATA_IN_W-1:0]  s_tdata,
    // tuser: cmd[1:0]
    input  logic [1:0]             s_tuser,
    // Output stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // tdata from bit 0: hour_out[7:0], minute_out[7:0], month_out[7:0],
    //                   day_out[7:0], year_out[7:0], position_out[3:0],
    //                   four zero bits
    output logic [TDATA_OUT_W-1:0] m_tdata,
    // tlast: done_next, the set that closes the editing session
    output logic                   m_tlast
);

    // State
    bcd_t hour_reg, minute_reg, month_reg, day_reg, year_reg;
    pos_t pos_reg;
    bcd_t hour_next, minute_next, month_next, day_next, year_next;
    pos_t pos_next;
    logic done_next;

    logic                   m_tvalid_reg;
    logic [TDATA_OUT_W-1:0] m_tdata_reg;
    logic                   m_tlast_reg;

    logic accept;
    logic active;
    cmd_t cmd;

    assign cmd      = cmd_t'(s_tuser);
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign active   = (pos_reg >= POS_FIRST) && (pos_reg <= POS_LAST);

    // Work out the next state for one word
    always_comb
    begin
        hour_next   = hour_reg;
        minute_next = minute_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        year_next   = year_reg;
        pos_next    = pos_reg;
        done_next   = 1'b0;

        if (cmd == CMD_LOAD)
        begin
            hour_next   = {2'b00, s_tdata[5:0]};
            minute_next = {1'b0, s_tdata[12:6]};
            month_next  = {3'b000, s_tdata[17:13]};
            day_next    = {2'b00, s_tdata[23:18]};
            year_next   = s_tdata[31:24];
            pos_next    = POS_FIRST;
        end
        else if (active)
        begin
            case (cmd)
                CMD_SET:
                begin
                    // Confirm clamps, then advance or finish
                    if (hour_next > BCD_23)
                        hour_next = BCD_20;
                    if (month_next > BCD_12)
                        month_next = BCD_10;
                    if (month_next == BCD_00)
                        month_next = BCD_01;
                    if (day_next == BCD_00)
                        day_next = BCD_01;
                    day_next = clamp_day(day_next, month_next, year_next,
                                         BCD_30, BCD_20, BCD_20);
                    if (pos_reg >= POS_LAST)
                    begin
                        pos_next  = POS_IDLE;
                        done_next = 1'b1;
                    end
                    else
                        pos_next = pos_t'(pos_reg + POS_FIRST);
                end
                CMD_UP:
                begin
                    case (pos_reg)
                        POS_HOUR_T:   hour_next = tens_up(hour_reg, 4'h2);
                        POS_HOUR_O:
                        begin
                            hour_next = ones_up(hour_reg);
                            if (hour_next > BCD_23)
                                hour_next = BCD_20;
                        end
                        POS_MINUTE_T: minute_next = tens_up(minute_reg, 4'h5);
                        POS_MINUTE_O: minute_next = ones_up(minute_reg);
                        POS_MONTH_T:  month_next = tens_up(month_reg, 4'h1);
                        POS_MONTH_O:
                        begin
                            month_next = ones_up(month_reg);
                            if (month_next > BCD_12)
                                month_next = BCD_10;
                            if (month_next == BCD_00)
                                month_next = BCD_01;
                        end
                        POS_DAY_T:    day_next = tens_up(day_reg, 4'h3);
                        POS_DAY_O:
                        begin
                            day_next = ones_up(day_reg);
                            if (day_next == BCD_00)
                                day_next = BCD_01;
                            day_next = clamp_day(day_next, month_reg, year_reg,
                                                 BCD_30, BCD_20, BCD_20);
                        end
                        POS_YEAR_T:   year_next = tens_up(year_reg, 4'h9);
                        POS_YEAR_O:   year_next = ones_up(year_reg);
                        default:      ;
                    endcase
                end
                CMD_DOWN:
                begin
                    case (pos_reg)
                        POS_HOUR_T:   hour_next = tens_down(hour_reg, BCD_20);
                        POS_HOUR_O:
                        begin
                            hour_next = ones_down(hour_reg);
                            if (hour_next > BCD_23)
                                hour_next = BCD_23;
                        end
                        POS_MINUTE_T: minute_next = tens_down(minute_reg, BCD_50);
                        POS_MINUTE_O: minute_next = ones_down(minute_reg);
                        POS_MONTH_T:  month_next = tens_down(month_reg, BCD_10);
                        POS_MONTH_O:
                        begin
                            month_next = ones_down(month_reg);
                            if (month_next > BCD_12)
                                month_next = BCD_10;
                            if (month_next == BCD_00)
                                month_next = BCD_09;
                        end
                        POS_DAY_T:
                            day_next = tens_down(day_reg,
                                                 (month_reg == BCD_02) ? BCD_20 : BCD_30);
                        POS_DAY_O:
                        begin
                            day_next = ones_down(day_reg);
                            if (day_next == BCD_00)
                                day_next = BCD_09;
                            day_next = clamp_day(day_next, month_reg, year_reg,
                                                 BCD_31, BCD_29, BCD_28);
                        end
                        POS_YEAR_T:   year_next = tens_down(year_reg, BCD_10);
                        POS_YEAR_O:   year_next = ones_down(year_reg);
                        default:      ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // Hold the state bytes and position; advance on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hour_reg   <= BCD_00;
            minute_reg <= BCD_00;
            month_reg  <= BCD_01;
            day_reg    <= BCD_01;
            year_reg   <= BCD_00;
            pos_reg    <= POS_IDLE;
        end
        else if (accept)
        begin
            hour_reg   <= hour_next;
            minute_reg <= minute_next;
            month_reg  <= month_next;
            day_reg    <= day_next;
            year_reg   <= year_next;
            pos_reg    <= pos_next;
        end
    end

    // Output valid: set on accept, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (accept)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    // Result word and end-of-session flag
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_tdata_reg <= {4'b0000, pos_next, year_next, day_next,
                            month_next, minute_next, hour_next};
            m_tlast_reg <= done_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // Position never leaves its legal range
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_LAST)
        else $error("edit position out of range");

    // A load always restarts at the first position
    a_load_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd == CMD_LOAD) |=> (pos_reg == POS_FIRST))
        else $error("load did not restart editing");

    // Done is only reported with the editor back to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tdata[43:40] == POS_IDLE))
        else $error("done raised with position not idle");

    // Input is refused only while a result is stalled
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input refused with output free");

    // State bytes hold without an accepted word
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> ($stable(hour_reg) && $stable(day_reg) && $stable(pos_reg)))
        else $error("state changed without an accepted word");

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for date_time_digit_editor
// Streams load and key words into the editor with random gaps and
// back-pressure. A local model of the digit rules predicts every result
// word. Each result is compared field by field against the oldest
// prediction.
// ----------------------------------------------------------------------------
module testbench;
    import dtde_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int RESET_LEN   = 7;
    localparam int WORD_TARGET = 1200;
    localparam int CALM_TAIL   = 150;
    localparam int DRAIN_WAIT  = 4;
    localparam int CYCLE_LIMIT = 200000;

    // One input word as queued for the feeder
    typedef struct {
        cmd_t       cmd;
        logic [5:0] hour;
        logic [6:0] minute;
        logic [4:0] month;
        logic [5:0] day;
        logic [7:0] year;
    } key_word_t;

    // Editor state as shown on one result word
    typedef struct packed {
        bcd_t hour;
        bcd_t minute;
        bcd_t month;
        bcd_t day;
        bcd_t year;
        pos_t pos;
        logic done;
    } clock_view_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata = '0;
    logic [1:0]             s_tuser = CMD_LOAD;
    logic                   m_tvalid;
    logic                   m_tready = 1'b1;
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic                   m_tlast;

    key_word_t   key_words[$];
    clock_view_t views_due[$];

    // Local copy of the editor state
    bcd_t ed_hour;
    bcd_t ed_minute;
    bcd_t ed_month;
    bcd_t ed_day;
    bcd_t ed_year;
    pos_t ed_pos;

    int mismatches      = 0;
    int words_taken     = 0;
    int results_checked = 0;
    int sessions_closed = 0;
    int planned_words   = 0;
    int send_hold       = 0;
    int ready_hold      = 0;
    int cycle_count     = 0;

    date_time_digit_editor dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Free-running clock
    always
    begin
        clk = 1'b1;
        #CLK_HALF;
        clk = 1'b0;
        #CLK_HALF;
    end

    // ------------------------------------------------------------------
    // Digit rules of the editor
    // ------------------------------------------------------------------
    function automatic bcd_t bump_tens(input bcd_t v, input bcd_t lim);
        if ({4'h0, v[7:4]} < lim)
            return v + 8'h10;
        return {4'h0, v[3:0]};
    endfunction

    function automatic bcd_t bump_ones(input bcd_t v);
        if (v[3:0] < 4'h9)
            return v + 8'h01;
        return {v[7:4], 4'h0};
    endfunction

    function automatic bcd_t drop_tens(input bcd_t v, input bcd_t wrap);
        if (v[7:4] == 4'h0)
            return v + wrap;
        return v - 8'h10;
    endfunction

    function automatic bcd_t drop_ones(input bcd_t v);
        if (v[3:0] == 4'h0)
            return v + 8'h09;
        return v - 8'h01;
    endfunction

    function automatic logic has_31_days(input bcd_t m);
        return m == 8'h01 || m == 8'h03 || m == 8'h05 || m == 8'h07 ||
               m == 8'h08 || m == 8'h10 || m == 8'h12;
    endfunction

    function automatic logic has_30_days(input bcd_t m);
        return m == 8'h04 || m == 8'h06 || m == 8'h09 || m == 8'h11;
    endfunction

    // Trim the day to the month length; leap only looks at year[1:0]
    function automatic void trim_day(input bcd_t c31, input bcd_t c29,
                                     input bcd_t c28);
        logic leap;
        leap = (ed_year[1:0] == 2'b00);
        if (ed_day > BCD_31 && has_31_days(ed_month))
            ed_day = c31;
        if (ed_day > BCD_30 && has_30_days(ed_month))
            ed_day = BCD_30;
        if (ed_day > BCD_29 && ed_month == BCD_02 && leap)
            ed_day = c29;
        if (ed_day > BCD_28 && ed_month == BCD_02 && !leap)
            ed_day = c28;
    endfunction

    // Apply one accepted word to the local state and return the view
    function automatic clock_view_t advance_clock(input cmd_t cmd,
                                                  input logic [31:0] w);
        clock_view_t v;
        logic        done;
        done = 1'b0;
        if (cmd == CMD_LOAD)
        begin
            ed_hour   = {2'b00, w[5:0]};
            ed_minute = {1'b0, w[12:6]};
            ed_month  = {3'b000, w[17:13]};
            ed_day    = {2'b00, w[23:18]};
            ed_year   = w[31:24];
            ed_pos    = POS_FIRST;
        end
        else if (ed_pos >= POS_FIRST && ed_pos <= POS_LAST)
        begin
            case (cmd)
                CMD_SET:
                begin
                    if (ed_hour > BCD_23)
                        ed_hour = BCD_20;
                    if (ed_month > BCD_12)
                        ed_month = BCD_10;
                    if (ed_month == BCD_00)
                        ed_month = BCD_01;
                    if (ed_day == BCD_00)
                        ed_day = BCD_01;
                    trim_day(BCD_30, BCD_20, BCD_20);
                    if (ed_pos >= POS_LAST)
                    begin
                        ed_pos = POS_IDLE;
                        done   = 1'b1;
                    end
                    else
                    begin
                        ed_pos = ed_pos + 4'd1;
                    end
                end
                CMD_UP:
                begin
                    case (ed_pos)
                        POS_HOUR_T:   ed_hour = bump_tens(ed_hour, 8'h02);
                        POS_HOUR_O:
                        begin
                            ed_hour = bump_ones(ed_hour);
                            if (ed_hour > BCD_23)
                                ed_hour = BCD_20;
                        end
                        POS_MINUTE_T: ed_minute = bump_tens(ed_minute, 8'h05);
                        POS_MINUTE_O: ed_minute = bump_ones(ed_minute);
                        POS_MONTH_T:  ed_month = bump_tens(ed_month, 8'h01);
                        POS_MONTH_O:
                        begin
                            ed_month = bump_ones(ed_month);
                            if (ed_month > BCD_12)
                                ed_month = BCD_10;
                            if (ed_month == BCD_00)
                                ed_month = BCD_01;
                        end
                        POS_DAY_T:    ed_day = bump_tens(ed_day, 8'h03);
                        POS_DAY_O:
                        begin
                            ed_day = bump_ones(ed_day);
                            if (ed_day == BCD_00)
                                ed_day = BCD_01;
                            trim_day(BCD_30, BCD_20, BCD_20);
                        end
                        POS_YEAR_T:   ed_year = bump_tens(ed_year, 8'h09);
                        POS_YEAR_O:   ed_year = bump_ones(ed_year);
                        default:      ;
                    endcase
                end
                default:
                begin
                    case (ed_pos)
                        POS_HOUR_T:   ed_hour = drop_tens(ed_hour, BCD_20);
                        POS_HOUR_O:
                        begin
                            ed_hour = drop_ones(ed_hour);
                            if (ed_hour > BCD_23)
                                ed_hour = BCD_23;
                        end
                        POS_MINUTE_T: ed_minute = drop_tens(ed_minute, BCD_50);
                        POS_MINUTE_O: ed_minute = drop_ones(ed_minute);
                        POS_MONTH_T:  ed_month = drop_tens(ed_month, BCD_10);
                        POS_MONTH_O:
                        begin
                            ed_month = drop_ones(ed_month);
                            if (ed_month > BCD_12)
                                ed_month = BCD_10;
                            if (ed_month == BCD_00)
                                ed_month = BCD_09;
                        end
                        POS_DAY_T:
                            ed_day = drop_tens(ed_day,
                                               ed_month == BCD_02 ? BCD_20 : BCD_30);
                        POS_DAY_O:
                        begin
                            ed_day = drop_ones(ed_day);
                            if (ed_day == BCD_00)
                                ed_day = BCD_09;
                            trim_day(BCD_31, BCD_29, BCD_28);
                        end
                        POS_YEAR_T:   ed_year = drop_tens(ed_year, BCD_10);
                        POS_YEAR_O:   ed_year = drop_ones(ed_year);
                        default:      ;
                    endcase
                end
            endcase
        end
        v.hour   = ed_hour;
        v.minute = ed_minute;
        v.month  = ed_month;
        v.day    = ed_day;
        v.year   = ed_year;
        v.pos    = ed_pos;
        v.done   = done;
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------
    function automatic bcd_t to_bcd(input int n);
        return bcd_t'(((n / 10) << 4) | (n % 10));
    endfunction

    task automatic queue_load(input bcd_t h, input bcd_t m, input bcd_t mo,
                              input bcd_t d, input bcd_t y);
        key_word_t k;
        k.cmd    = CMD_LOAD;
        k.hour   = h[5:0];
        k.minute = m[6:0];
        k.month  = mo[4:0];
        k.day    = d[5:0];
        k.year   = y;
        key_words.push_back(k);
    endtask

    // Keys carry random payload; the editor must ignore it
    task automatic queue_key(input cmd_t c);
        key_word_t k;
        k.cmd    = c;
        k.hour   = 6'($urandom);
        k.minute = 7'($urandom);
        k.month  = 5'($urandom);
        k.day    = 6'($urandom);
        k.year   = 8'($urandom);
        key_words.push_back(k);
    endtask

    // Mostly valid dates, biased to February and month ends; some raw bits
    task automatic queue_random_load();
        bcd_t mo;
        bcd_t d;
        if ($urandom_range(0, 3) == 0)
        begin
            queue_load(8'($urandom), 8'($urandom), 8'($urandom),
                       8'($urandom), 8'($urandom));
        end
        else
        begin
            mo = ($urandom_range(0, 3) == 0) ? BCD_02 : to_bcd($urandom_range(1, 12));
            d  = ($urandom_range(0, 2) == 0) ? to_bcd($urandom_range(28, 31))
                                             : to_bcd($urandom_range(1, 31));
            queue_load(to_bcd($urandom_range(0, 23)), to_bcd($urandom_range(0, 59)),
                       mo, d, to_bcd($urandom_range(0, 99)));
        end
    endtask

    function automatic cmd_t pick_step();
        return ($urandom_range(0, 1) == 0) ? CMD_UP : CMD_DOWN;
    endfunction

    task automatic queue_directed();
        // keys while idle do nothing
        queue_key(CMD_SET);
        queue_key(CMD_UP);
        queue_key(CMD_DOWN);
        // out-of-range load with every bit high, then confirm clamps
        queue_load(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        queue_key(CMD_UP);
        queue_key(CMD_SET);
        // reload mid-session with zeros and walk every position to done
        queue_load(BCD_00, BCD_00, BCD_00, BCD_00, BCD_00);
        queue_key(CMD_DOWN);
        queue_key(CMD_SET);
        queue_key(CMD_DOWN);
        queue_key(CMD_UP);
        queue_key(CMD_SET);
        queue_key(CMD_DOWN);
        queue_key(CMD_SET);
        queue_key(CMD_DOWN);
        queue_key(CMD_SET);
        queue_key(CMD_DOWN);
        queue_key(CMD_SET);
        queue_key(CMD_UP);
        for (int i = 0; i < 6; i++)
            queue_key(CMD_SET);
        planned_words = key_words.size();
    endtask

    task automatic queue_random();
        int kind;
        int n;
        while (planned_words < WORD_TARGET)
        begin
            kind = $urandom_range(0, 9);
            queue_random_load();
            planned_words++;
            if (kind == 0)
            begin
                // broken session: a few keys, then abandoned by the next load
                n = $urandom_range(0, 12);
                for (int i = 0; i < n; i++)
                    queue_key(cmd_t'($urandom_range(1, 3)));
                planned_words += n;
            end
            else
            begin
                // full session through all ten positions
                for (int p = 0; p < 10; p++)
                begin
                    n = $urandom_range(0, 6);
                    for (int i = 0; i < n; i++)
                        queue_key(pick_step());
                    queue_key(CMD_SET);
                    planned_words += n + 1;
                end
                // occasional stray keys while idle
                if (kind == 1)
                begin
                    n = $urandom_range(1, 3);
                    for (int i = 0; i < n; i++)
                        queue_key(cmd_t'($urandom_range(1, 3)));
                    planned_words += n;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Feeder: present queued words, with random gaps outside the tail
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : feed_proc
        key_word_t k;
        if (rst_n && !(s_tvalid && !s_tready))
        begin
            if (send_hold > 0)
            begin
                send_hold = send_hold - 1;
                s_tvalid <= 1'b0;
            end
            else if (key_words.size() > CALM_TAIL && $urandom_range(0, 5) == 0)
            begin
                send_hold = $urandom_range(0, 9);
                s_tvalid <= 1'b0;
            end
            else if (key_words.size() != 0)
            begin
                k = key_words.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {k.year, k.day, k.month, k.minute, k.hour};
                s_tuser  <= k.cmd;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected 0x%02h, got 0x%02h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: check result words, predict from accepted input words,
    // and drive back-pressure
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : watch_proc
        clock_view_t got;
        clock_view_t want;
        if (rst_n)
        begin
            // compare the result word with the oldest prediction
            if (m_tvalid && m_tready)
            begin
                got.hour   = m_tdata[7:0];
                got.minute = m_tdata[15:8];
                got.month  = m_tdata[23:16];
                got.day    = m_tdata[31:24];
                got.year   = m_tdata[39:32];
                got.pos    = m_tdata[43:40];
                got.done   = m_tlast;
                if (views_due.size() == 0)
                begin
                    $display("%0t: unexpected result word 0x%012h", $time, m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = views_due.pop_front();
                    check_field("hour", want.hour, got.hour);
                    check_field("minute", want.minute, got.minute);
                    check_field("month", want.month, got.month);
                    check_field("day", want.day, got.day);
                    check_field("year", want.year, got.year);
                    check_field("position", want.pos, got.pos);
                    check_field("done", want.done, got.done);
                    if (want.done)
                        sessions_closed++;
                    results_checked++;
                end
            end
            // predict from the word taken at this edge
            if (s_tvalid && s_tready)
            begin
                views_due.push_back(advance_clock(cmd_t'(s_tuser), s_tdata));
                words_taken++;
            end
            // stall the result side in bursts, never in the tail
            if (ready_hold > 0)
            begin
                ready_hold = ready_hold - 1;
                m_tready <= 1'b0;
            end
            else if (key_words.size() > CALM_TAIL && $urandom_range(0, 5) == 0)
            begin
                ready_hold = $urandom_range(0, 9);
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Guard against a hung handshake
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        ed_hour   = BCD_00;
        ed_minute = BCD_00;
        ed_month  = BCD_01;
        ed_day    = BCD_01;
        ed_year   = BCD_00;
        ed_pos    = POS_IDLE;
        queue_directed();
        queue_random();

        // hold reset, then release on an edge
        repeat (RESET_LEN) @(posedge clk);
        rst_n <= 1'b1;

        // wait until every word is taken and every result checked
        do
            @(posedge clk);
        while (key_words.size() != 0 || s_tvalid || views_due.size() != 0);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("%0d words sent, %0d results checked, %0d editing sessions completed",
                 words_taken, results_checked, sessions_closed);
        $display("covered idle keys, reloads mid-session, raw bytes and day clamps");
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/dtde_pkg.sv
hw/rtl/date_time_digit_editor.sv
sim/testbench.sv
